FILE: sv/turing_machine_step_macros.svh
// Assertion macros for the top module of the Turing machine block.
`ifndef TURING_MACHINE_STEP_MACROS_SVH
`define TURING_MACHINE_STEP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TMS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tms: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define TMS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tms: next-cycle check failed");

`endif

FILE: sv/tms_pkg.sv
package tms_pkg;

    localparam int TAPE_DEPTH_DEF = 64;
    localparam int RULE_DEPTH_DEF = 16;

    localparam int OP_W       = 2;
    localparam int SYM_W      = 8;
    localparam int STATE_W    = 8;
    localparam int HEAD_W     = 6;
    localparam int CELL_IDX_W = 6;
    localparam int RULE_IDX_W = 4;
    localparam int MOVE_W     = 2;
    localparam int STATUS_W   = 3;
    localparam int RULE_CNT_W = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [OP_W-1:0] OP_LOAD_RULE = 2'd0;
    localparam logic [OP_W-1:0] OP_LOAD_CELL = 2'd1;
    localparam logic [OP_W-1:0] OP_STEP      = 2'd2;
    localparam logic [OP_W-1:0] OP_RESTART   = 2'd3;

    localparam logic [MOVE_W-1:0] MV_LEFT  = 2'd0;
    localparam logic [MOVE_W-1:0] MV_RIGHT = 2'd1;

    localparam logic [STATUS_W-1:0] ST_STEPPED = 3'd0;
    localparam logic [STATUS_W-1:0] ST_MARK    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_STOP    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NORULE  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_OFFTAPE = 3'd4;
    localparam logic [STATUS_W-1:0] ST_LOADED  = 3'd5;

    localparam logic [CFG_IDX_W-1:0] CFG_START_STATE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_HEAD  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RULE_COUNT  = 2'd2;

    localparam logic [SYM_W-1:0] HALT_MARK = 8'h23;

    typedef struct packed {
        logic [OP_W-1:0]       operation;
        logic [RULE_IDX_W-1:0] rule_index;
        logic [SYM_W-1:0]      rule_symbol;
        logic [STATE_W-1:0]    rule_state;
        logic [SYM_W-1:0]      rule_write;
        logic [STATE_W-1:0]    rule_next_state;
        logic [MOVE_W-1:0]     rule_move;
        logic [CELL_IDX_W-1:0] cell_index;
        logic [SYM_W-1:0]      cell_symbol;
    } t_in;

    typedef struct packed {
        logic [SYM_W-1:0]    out_symbol;
        logic [STATE_W-1:0]  out_state;
        logic [HEAD_W-1:0]   out_head;
        logic [STATUS_W-1:0] status;
    } t_out;

    typedef struct packed {
        logic [SYM_W-1:0]   sym;
        logic [STATE_W-1:0] st;
        logic [SYM_W-1:0]   wr;
        logic [STATE_W-1:0] nst;
        logic [MOVE_W-1:0]  mv;
    } t_rule;

    typedef struct packed {
        logic               hit;
        logic [SYM_W-1:0]   wr;
        logic [STATE_W-1:0] nst;
        logic [MOVE_W-1:0]  mv;
    } t_hit;

endpackage

FILE: sv/turing_machine_step.sv
// Single-tape Turing machine with a tape memory and a rule table.
// Input channel (i_in_valid, o_in_ready, i_in) carries one item per transfer:
// load rule, load tape cell, run one step, or restart. Every item gives exactly
// one result transfer on the output channel (o_out_valid, i_out_ready, o_out)
// with the symbol under the head, the machine state, the head and a status.
// The configuration channel (i_cfg_valid, o_cfg_ready, i_cfg_index,
// i_cfg_data) is always ready and sets the start state, the start head and the
// number of rules searched; the user must write it only while the block is
// idle, as the block itself does not enforce this. Every item passes the
// read state and then the execute state; a step that moves the head returns
// to the read state once more. The single tape read port sets this: one read
// at the head, the rule compare and tape write, and for a move a second read
// at the new head. A new item is taken the cycle after its predecessor's
// result enters the output register, so items do not overlap in the block.
// A stalled receiver holds the result in the output register; the next item
// still runs and its result waits in a holding register until the slot frees.
// Synchronous reset clears the head, the state, the halt flag and the
// configuration; tape and rule contents stay undefined until loaded.
`include "turing_machine_step_macros.svh"

module turing_machine_step #(
    parameter int TAPE_DEPTH = tms_pkg::TAPE_DEPTH_DEF,
    parameter int RULE_DEPTH = tms_pkg::RULE_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  tms_pkg::t_in                  i_in,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output tms_pkg::t_out                 o_out,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [tms_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [tms_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int TA_W = $clog2(TAPE_DEPTH);
    localparam int HW = (TA_W > tms_pkg::HEAD_W) ? TA_W : tms_pkg::HEAD_W;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RD   = 2'd1;
    localparam logic [1:0] S_EX   = 2'd2;
    localparam logic [1:0] S_WT   = 2'd3;

    logic [1:0]                      r_fsm;
    logic [1:0]                      n_fsm;
    logic [tms_pkg::OP_W-1:0]        r_op;
    logic                            r_reread;
    logic [tms_pkg::STATE_W-1:0]     r_state;
    logic [HW-1:0]                   r_head;
    logic                            r_halted;
    logic [tms_pkg::STATUS_W-1:0]    r_halt_code;
    logic [tms_pkg::STATE_W-1:0]     r_start_state;
    logic [tms_pkg::HEAD_W-1:0]      r_start_head;
    logic [tms_pkg::RULE_CNT_W-1:0]  r_rule_count;
    logic                            r_out_valid;
    tms_pkg::t_out                   r_out;
    tms_pkg::t_out                   r_res;

    logic                            in_xfer;
    logic                            slot_free;
    logic                            head_ok;
    logic                            cell_we;
    logic                            tape_we;
    logic                            tape_re;
    logic [TA_W-1:0]                 tape_waddr;
    logic [tms_pkg::SYM_W-1:0]       tape_wdata;
    logic [tms_pkg::SYM_W-1:0]       tape_rdata;
    tms_pkg::t_rule                  new_rule;
    tms_pkg::t_hit                   hit;

    logic                            ex_final;
    logic                            ex_twe;
    logic                            ex_upd_state;
    logic                            ex_move;
    logic [HW-1:0]                   ex_head;
    logic                            ex_halt;
    logic [tms_pkg::STATUS_W-1:0]    ex_code;
    tms_pkg::t_out                   ex_res;

    assign o_in_ready  = (r_fsm == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    assign in_xfer   = i_in_valid && o_in_ready;
    assign slot_free = !r_out_valid || i_out_ready;
    assign head_ok   = (32'(r_head) < TAPE_DEPTH);

    assign cell_we = in_xfer && (i_in.operation == tms_pkg::OP_LOAD_CELL)
                     && (32'(i_in.cell_index) < TAPE_DEPTH);
    assign tape_we    = cell_we || ((r_fsm == S_EX) && ex_twe);
    assign tape_waddr = cell_we ? TA_W'(i_in.cell_index) : TA_W'(r_head);
    assign tape_wdata = cell_we ? i_in.cell_symbol : hit.wr;
    assign tape_re    = (r_fsm == S_RD) && head_ok;

    assign new_rule.sym = i_in.rule_symbol;
    assign new_rule.st  = i_in.rule_state;
    assign new_rule.wr  = i_in.rule_write;
    assign new_rule.nst = i_in.rule_next_state;
    assign new_rule.mv  = i_in.rule_move;

    tms_tape_ram #(
        .DEPTH(TAPE_DEPTH)
    ) u_tape (
        .i_clk  (i_clk),
        .i_we   (tape_we),
        .i_waddr(tape_waddr),
        .i_wdata(tape_wdata),
        .i_re   (tape_re),
        .i_raddr(TA_W'(r_head)),
        .o_rdata(tape_rdata)
    );

    tms_rule_match #(
        .DEPTH(RULE_DEPTH)
    ) u_rules (
        .i_clk  (i_clk),
        .i_we   (in_xfer && (i_in.operation == tms_pkg::OP_LOAD_RULE)),
        .i_widx (i_in.rule_index),
        .i_wrule(new_rule),
        .i_count(r_rule_count),
        .i_sym  (tape_rdata),
        .i_state(r_state),
        .o_hit  (hit)
    );

    always_comb begin
        ex_final          = 1'b1;
        ex_twe            = 1'b0;
        ex_upd_state      = 1'b0;
        ex_move           = 1'b0;
        ex_head           = r_head;
        ex_halt           = 1'b0;
        ex_code           = r_halt_code;
        ex_res.out_symbol = head_ok ? tape_rdata : '0;
        ex_res.out_state  = r_state;
        ex_res.out_head   = r_head[tms_pkg::HEAD_W-1:0];
        ex_res.status     = tms_pkg::ST_LOADED;
        if (r_op == tms_pkg::OP_STEP) begin
            if (r_reread) begin
                ex_res.status = tms_pkg::ST_STEPPED;
            end else if (r_halted) begin
                ex_res.status = r_halt_code;
            end else if (!head_ok) begin
                ex_halt = 1'b1;
                ex_code = tms_pkg::ST_OFFTAPE;
            end else if (tape_rdata == tms_pkg::HALT_MARK) begin
                ex_halt = 1'b1;
                ex_code = tms_pkg::ST_MARK;
            end else if (!hit.hit) begin
                ex_halt = 1'b1;
                ex_code = tms_pkg::ST_NORULE;
            end else begin
                ex_twe            = 1'b1;
                ex_upd_state      = 1'b1;
                ex_res.out_symbol = hit.wr;
                ex_res.out_state  = hit.nst;
                if (hit.mv == tms_pkg::MV_LEFT) begin
                    if (r_head == '0) begin
                        ex_halt = 1'b1;
                        ex_code = tms_pkg::ST_OFFTAPE;
                    end else begin
                        ex_final = 1'b0;
                        ex_move  = 1'b1;
                        ex_head  = r_head - HW'(1);
                    end
                end else if (hit.mv == tms_pkg::MV_RIGHT) begin
                    if (32'(r_head) + 32'd1 >= TAPE_DEPTH) begin
                        ex_halt = 1'b1;
                        ex_code = tms_pkg::ST_OFFTAPE;
                    end else begin
                        ex_final = 1'b0;
                        ex_move  = 1'b1;
                        ex_head  = r_head + HW'(1);
                    end
                end else begin
                    ex_halt = 1'b1;
                    ex_code = tms_pkg::ST_STOP;
                end
            end
            if (ex_halt) begin
                ex_res.status = ex_code;
            end
        end
    end

    always_comb begin
        n_fsm = r_fsm;
        case (r_fsm)
            S_IDLE: begin
                if (in_xfer) begin
                    n_fsm = S_RD;
                end
            end
            S_RD: begin
                n_fsm = S_EX;
            end
            S_EX: begin
                if (!ex_final) begin
                    n_fsm = S_RD;
                end else if (slot_free) begin
                    n_fsm = S_IDLE;
                end else begin
                    n_fsm = S_WT;
                end
            end
            S_WT: begin
                if (slot_free) begin
                    n_fsm = S_IDLE;
                end
            end
            default: begin
                n_fsm = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm         <= S_IDLE;
            r_op          <= tms_pkg::OP_LOAD_RULE;
            r_reread      <= 1'b0;
            r_state       <= '0;
            r_head        <= '0;
            r_halted      <= 1'b0;
            r_halt_code   <= '0;
            r_start_state <= '0;
            r_start_head  <= '0;
            r_rule_count  <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_fsm <= n_fsm;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    tms_pkg::CFG_START_STATE: begin
                        r_start_state <= i_cfg_data;
                    end
                    tms_pkg::CFG_START_HEAD: begin
                        r_start_head <= i_cfg_data[tms_pkg::HEAD_W-1:0];
                    end
                    tms_pkg::CFG_RULE_COUNT: begin
                        r_rule_count <= i_cfg_data[tms_pkg::RULE_CNT_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
            if (in_xfer) begin
                r_op     <= i_in.operation;
                r_reread <= 1'b0;
                if (i_in.operation == tms_pkg::OP_RESTART) begin
                    r_head      <= HW'(r_start_head);
                    r_state     <= r_start_state;
                    r_halted    <= 1'b0;
                    r_halt_code <= '0;
                end
            end
            if (r_fsm == S_EX) begin
                if (ex_upd_state) begin
                    r_state <= hit.nst;
                end
                if (ex_move) begin
                    r_head   <= ex_head;
                    r_reread <= 1'b1;
                end
                if (ex_halt) begin
                    r_halted    <= 1'b1;
                    r_halt_code <= ex_code;
                end
            end
            if ((r_fsm == S_EX && ex_final && slot_free) || (r_fsm == S_WT && slot_free)) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_fsm == S_EX && ex_final) begin
            if (slot_free) begin
                r_out <= ex_res;
            end else begin
                r_res <= ex_res;
            end
        end else if (r_fsm == S_WT && slot_free) begin
            r_out <= r_res;
        end
    end

    `TMS_ASSERT_NXT(a_busy_after_xfer, i_clk, i_rst_n, in_xfer, !o_in_ready)
    `TMS_ASSERT_IMP(a_tape_one_port, i_clk, i_rst_n, tape_we, !tape_re)
    `TMS_ASSERT_NXT(a_read_then_eval, i_clk, i_rst_n, r_fsm == S_RD, r_fsm == S_EX)
    `TMS_ASSERT_NXT(a_move_rereads, i_clk, i_rst_n, r_fsm == S_EX && !ex_final, (r_fsm == S_RD) && r_reread)

endmodule

FILE: sv/tms_tape_ram.sv
module tms_tape_ram #(
    parameter int DEPTH = tms_pkg::TAPE_DEPTH_DEF,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [AW-1:0]            i_waddr,
    input  logic [tms_pkg::SYM_W-1:0] i_wdata,
    input  logic                     i_re,
    input  logic [AW-1:0]            i_raddr,
    output logic [tms_pkg::SYM_W-1:0] o_rdata
);

    logic [tms_pkg::SYM_W-1:0] r_mem [DEPTH];
    logic [tms_pkg::SYM_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/tms_rule_match.sv
module tms_rule_match #(
    parameter int DEPTH = tms_pkg::RULE_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_we,
    input  logic [tms_pkg::RULE_IDX_W-1:0] i_widx,
    input  tms_pkg::t_rule                i_wrule,
    input  logic [tms_pkg::RULE_CNT_W-1:0] i_count,
    input  logic [tms_pkg::SYM_W-1:0]      i_sym,
    input  logic [tms_pkg::STATE_W-1:0]    i_state,
    output tms_pkg::t_hit                 o_hit
);

    tms_pkg::t_rule r_rules [DEPTH];

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < DEPTH; i++) begin
            if (i_we && int'(i_widx) == i) begin
                r_rules[i] <= i_wrule;
            end
        end
    end

    // The lowest matching slot below the rule count wins.
    always_comb begin
        o_hit = '0;
        for (int i = DEPTH - 1; i >= 0; i--) begin
            if (int'(i_count) > i && r_rules[i].sym == i_sym && r_rules[i].st == i_state) begin
                o_hit.hit = 1'b1;
                o_hit.wr  = r_rules[i].wr;
                o_hit.nst = r_rules[i].nst;
                o_hit.mv  = r_rules[i].mv;
            end
        end
    end

endmodule

FILE: test/turing_machine_step_tb.sv
`timescale 1ns / 100ps

module turing_machine_step_tb;

    localparam logic [tms_pkg::MOVE_W-1:0] MV_HALT     = 2'd2;
    localparam logic [tms_pkg::MOVE_W-1:0] MV_HALT_ALT = 2'd3;
    localparam int QUIET_LIMIT = 2000;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           in_valid = 1'b0;
    logic                           in_ready;
    tms_pkg::t_in                   in_item = '0;
    logic                           out_valid;
    logic                           out_ready = 1'b0;
    tms_pkg::t_out                  out_item;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [tms_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [tms_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    // Machine predictor: tape, rule table, head, state and registers.
    logic [tms_pkg::SYM_W-1:0]      tape_mem [tms_pkg::TAPE_DEPTH_DEF];
    tms_pkg::t_rule                 rule_mem [tms_pkg::RULE_DEPTH_DEF];
    logic [tms_pkg::STATE_W-1:0]    cur_state = '0;
    logic [tms_pkg::HEAD_W-1:0]     cur_head = '0;
    logic                           halted_flag = 1'b0;
    logic [tms_pkg::STATUS_W-1:0]   halt_status = tms_pkg::ST_STEPPED;
    logic [tms_pkg::STATE_W-1:0]    start_state_reg = '0;
    logic [tms_pkg::HEAD_W-1:0]     start_head_reg = '0;
    logic [tms_pkg::RULE_CNT_W-1:0] rule_count_reg = '0;

    tms_pkg::t_out pending_results [$];
    int   errors = 0;
    int   items_sent = 0;
    int   steps_run = 0;
    int   halts_seen = 0;
    int   tx_idle_pct = 0;
    int   rx_idle_pct = 0;
    int   hold_request = 0;
    int   hold_left = 0;
    int   quiet_cycles = 0;

    turing_machine_step uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #2 i_clk = ~i_clk;

    function automatic logic [tms_pkg::STATUS_W-1:0] halt_with(
            input logic [tms_pkg::STATUS_W-1:0] code);
        halted_flag = 1'b1;
        halt_status = code;
        halts_seen++;
        return code;
    endfunction

    function automatic logic [tms_pkg::STATUS_W-1:0] step_machine();
        logic [tms_pkg::SYM_W-1:0] sym;
        int limit;
        int hit;
        if (halted_flag) begin
            return halt_status;
        end
        sym = tape_mem[cur_head];
        if (sym == tms_pkg::HALT_MARK) begin
            return halt_with(tms_pkg::ST_MARK);
        end
        limit = (rule_count_reg > tms_pkg::RULE_DEPTH_DEF) ? tms_pkg::RULE_DEPTH_DEF
                                                            : int'(rule_count_reg);
        hit = -1;
        for (int i = 0; i < limit && hit < 0; i++) begin
            if (rule_mem[i].sym == sym && rule_mem[i].st == cur_state) begin
                hit = i;
            end
        end
        if (hit < 0) begin
            return halt_with(tms_pkg::ST_NORULE);
        end
        tape_mem[cur_head] = rule_mem[hit].wr;
        cur_state = rule_mem[hit].nst;
        if (rule_mem[hit].mv == tms_pkg::MV_LEFT) begin
            if (cur_head == 0) begin
                return halt_with(tms_pkg::ST_OFFTAPE);
            end
            cur_head = cur_head - 1'b1;
        end else if (rule_mem[hit].mv == tms_pkg::MV_RIGHT) begin
            if (int'(cur_head) + 1 >= tms_pkg::TAPE_DEPTH_DEF) begin
                return halt_with(tms_pkg::ST_OFFTAPE);
            end
            cur_head = cur_head + 1'b1;
        end else begin
            return halt_with(tms_pkg::ST_STOP);
        end
        return tms_pkg::ST_STEPPED;
    endfunction

    function automatic tms_pkg::t_out machine_apply(input tms_pkg::t_in item);
        tms_pkg::t_out res;
        logic [tms_pkg::STATUS_W-1:0] status;
        status = tms_pkg::ST_LOADED;
        case (item.operation)
            tms_pkg::OP_LOAD_RULE: begin
                rule_mem[item.rule_index] = '{item.rule_symbol, item.rule_state,
                    item.rule_write, item.rule_next_state, item.rule_move};
            end
            tms_pkg::OP_LOAD_CELL: begin
                tape_mem[item.cell_index] = item.cell_symbol;
            end
            tms_pkg::OP_STEP: begin
                steps_run++;
                status = step_machine();
            end
            default: begin
                cur_head = start_head_reg;
                cur_state = start_state_reg;
                halted_flag = 1'b0;
                halt_status = tms_pkg::ST_STEPPED;
            end
        endcase
        res.out_symbol = tape_mem[cur_head];
        res.out_state = cur_state;
        res.out_head = cur_head;
        res.status = status;
        return res;
    endfunction

    function automatic tms_pkg::t_in random_item();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[$bits(tms_pkg::t_in)-1:0];
    endfunction

    function automatic tms_pkg::t_in rule_item(input logic [tms_pkg::RULE_IDX_W-1:0] idx,
                                               input logic [tms_pkg::SYM_W-1:0] sym,
                                               input logic [tms_pkg::STATE_W-1:0] st,
                                               input logic [tms_pkg::SYM_W-1:0] wr,
                                               input logic [tms_pkg::STATE_W-1:0] nst,
                                               input logic [tms_pkg::MOVE_W-1:0] mv);
        tms_pkg::t_in it;
        it = random_item();
        it.operation = tms_pkg::OP_LOAD_RULE;
        it.rule_index = idx;
        it.rule_symbol = sym;
        it.rule_state = st;
        it.rule_write = wr;
        it.rule_next_state = nst;
        it.rule_move = mv;
        return it;
    endfunction

    function automatic tms_pkg::t_in cell_item(input logic [tms_pkg::CELL_IDX_W-1:0] idx,
                                               input logic [tms_pkg::SYM_W-1:0] sym);
        tms_pkg::t_in it;
        it = random_item();
        it.operation = tms_pkg::OP_LOAD_CELL;
        it.cell_index = idx;
        it.cell_symbol = sym;
        return it;
    endfunction

    function automatic tms_pkg::t_in op_item(input logic [tms_pkg::OP_W-1:0] op);
        tms_pkg::t_in it;
        it = random_item();
        it.operation = op;
        return it;
    endfunction

    function automatic logic [tms_pkg::MOVE_W-1:0] pick_move();
        int r;
        r = $urandom_range(19);
        if (r == 0) begin
            return MV_HALT;
        end else if (r == 1) begin
            return MV_HALT_ALT;
        end
        return ($urandom_range(1) == 1) ? tms_pkg::MV_RIGHT : tms_pkg::MV_LEFT;
    endfunction

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
        end
    endtask

    task automatic send_item(input tms_pkg::t_in item);
        while ($urandom_range(99) < tx_idle_pct) begin
            in_valid = 1'b0;
            @(negedge i_clk);
        end
        in_item = item;
        in_valid = 1'b1;
        @(posedge i_clk);
        while (!in_ready) begin
            @(posedge i_clk);
        end
        pending_results.push_back(machine_apply(item));
        items_sent++;
        @(negedge i_clk);
        in_valid = 1'b0;
    endtask

    task automatic send_mixed(input tms_pkg::t_in item);
        if ($urandom_range(99) < 12) begin
            send_item(random_item());
        end
        send_item(item);
    endtask

    task automatic drain_results();
        while (pending_results.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_register(input logic [tms_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [tms_pkg::CFG_DATA_W-1:0] value);
        cfg_index = idx;
        cfg_data = value;
        cfg_valid = 1'b1;
        @(posedge i_clk);
        while (!cfg_ready) begin
            @(posedge i_clk);
        end
        case (idx)
            tms_pkg::CFG_START_STATE: start_state_reg = value;
            tms_pkg::CFG_START_HEAD:  start_head_reg = value[tms_pkg::HEAD_W-1:0];
            tms_pkg::CFG_RULE_COUNT:  rule_count_reg = value[tms_pkg::RULE_CNT_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        cfg_valid = 1'b0;
    endtask

    task automatic configure(input logic [tms_pkg::STATE_W-1:0] st,
                             input logic [tms_pkg::HEAD_W-1:0] hd,
                             input logic [tms_pkg::RULE_CNT_W-1:0] cnt);
        drain_results();
        write_register(tms_pkg::CFG_START_STATE, st);
        write_register(tms_pkg::CFG_START_HEAD, tms_pkg::CFG_DATA_W'(hd));
        write_register(tms_pkg::CFG_RULE_COUNT, tms_pkg::CFG_DATA_W'(cnt));
    endtask

    // A small random machine: rules over a three-symbol alphabet and three states,
    // a tape window around the start head, then steps until a halt or a limit.
    task automatic run_program();
        logic [tms_pkg::SYM_W-1:0]   alphabet [3];
        logic [tms_pkg::STATE_W-1:0] states [3];
        logic [tms_pkg::SYM_W-1:0]   wr;
        int slots;
        int extra;
        for (int k = 0; k < 3; k++) begin
            alphabet[k] = tms_pkg::SYM_W'($urandom_range(255));
            if (alphabet[k] == tms_pkg::HALT_MARK) begin
                alphabet[k] = ~tms_pkg::HALT_MARK;
            end
            states[k] = tms_pkg::STATE_W'($urandom_range(255));
        end
        states[0] = start_state_reg;
        slots = (rule_count_reg > tms_pkg::RULE_DEPTH_DEF) ? tms_pkg::RULE_DEPTH_DEF
                                                            : int'(rule_count_reg);
        if (slots == 0) begin
            slots = 2;
        end
        for (int r = 0; r < slots; r++) begin
            case ($urandom_range(19))
                0:       wr = tms_pkg::HALT_MARK;
                1:       wr = tms_pkg::SYM_W'($urandom_range(255));
                default: wr = alphabet[$urandom_range(2)];
            endcase
            send_mixed(rule_item(tms_pkg::RULE_IDX_W'(r), alphabet[$urandom_range(2)],
                states[$urandom_range(2)], wr, states[$urandom_range(2)], pick_move()));
        end
        for (int k = -6; k <= 6; k++) begin
            send_mixed(cell_item(tms_pkg::CELL_IDX_W'(int'(start_head_reg) + k),
                ($urandom_range(99) < 8) ? tms_pkg::HALT_MARK : alphabet[$urandom_range(2)]));
        end
        send_mixed(op_item(tms_pkg::OP_RESTART));
        extra = $urandom_range(2);
        repeat ($urandom_range(40, 8)) begin
            if (halted_flag) begin
                if (extra == 0) begin
                    break;
                end
                extra--;
            end
            send_mixed(op_item(tms_pkg::OP_STEP));
        end
    endtask

    task automatic load_machine();
        for (int c = 0; c < tms_pkg::TAPE_DEPTH_DEF; c++) begin
            send_item(cell_item(tms_pkg::CELL_IDX_W'(c), tms_pkg::SYM_W'($urandom_range(255))));
        end
        for (int r = 0; r < tms_pkg::RULE_DEPTH_DEF; r++) begin
            send_item(rule_item(tms_pkg::RULE_IDX_W'(r), tms_pkg::SYM_W'($urandom_range(255)),
                tms_pkg::STATE_W'($urandom_range(255)), tms_pkg::SYM_W'($urandom_range(255)),
                tms_pkg::STATE_W'($urandom_range(255)), tms_pkg::MOVE_W'($urandom_range(3))));
        end
    endtask

    task automatic test_directed();
        configure(8'hFF, 6'd63, 5'd2);
        send_item(rule_item(4'd0, 8'hFF, 8'hFF, 8'h00, 8'h00, tms_pkg::MV_RIGHT));
        send_item(rule_item(4'd1, 8'h41, 8'h00, 8'h42, 8'h01, tms_pkg::MV_LEFT));
        send_item(cell_item(6'd63, 8'hFF));
        send_item(op_item(tms_pkg::OP_RESTART));
        send_item(op_item(tms_pkg::OP_STEP));
        send_item(op_item(tms_pkg::OP_STEP));
        send_item(op_item(tms_pkg::OP_RESTART));
        send_item(op_item(tms_pkg::OP_STEP));
        configure(8'h00, 6'd0, 5'd2);
        send_item(cell_item(6'd0, 8'h41));
        send_item(op_item(tms_pkg::OP_RESTART));
        send_item(op_item(tms_pkg::OP_STEP));
        send_item(cell_item(6'd0, tms_pkg::HALT_MARK));
        send_item(op_item(tms_pkg::OP_RESTART));
        send_item(op_item(tms_pkg::OP_STEP));
        send_item(rule_item(4'd0, 8'h10, 8'h00, 8'h11, 8'h20, MV_HALT));
        send_item(cell_item(6'd0, 8'h10));
        send_item(op_item(tms_pkg::OP_RESTART));
        send_item(op_item(tms_pkg::OP_STEP));
        send_item(rule_item(4'd0, 8'h11, 8'h00, 8'h11, 8'h20, MV_HALT_ALT));
        send_item(op_item(tms_pkg::OP_RESTART));
        send_item(op_item(tms_pkg::OP_STEP));
        // Both rules match; the lower slot must win.
        send_item(rule_item(4'd0, 8'h11, 8'h00, 8'h11, 8'h00, tms_pkg::MV_RIGHT));
        send_item(rule_item(4'd1, 8'h11, 8'h00, 8'hFF, 8'hFF, tms_pkg::MV_LEFT));
        send_item(cell_item(6'd1, 8'h11));
        send_item(op_item(tms_pkg::OP_RESTART));
        send_item(op_item(tms_pkg::OP_STEP));
        send_item(op_item(tms_pkg::OP_STEP));
        configure(8'h00, 6'd0, 5'd0);
        send_item(op_item(tms_pkg::OP_RESTART));
        send_item(op_item(tms_pkg::OP_STEP));
        configure(8'h00, 6'd0, 5'd31);
        send_item(op_item(tms_pkg::OP_RESTART));
        send_item(op_item(tms_pkg::OP_STEP));
    endtask

    task automatic test_random_mix(input int tx_pct, input int rx_pct,
                                   input logic [tms_pkg::STATE_W-1:0] st,
                                   input logic [tms_pkg::HEAD_W-1:0] hd,
                                   input logic [tms_pkg::RULE_CNT_W-1:0] cnt);
        int first;
        configure(st, hd, cnt);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        first = items_sent;
        while (items_sent - first < 510) begin
            run_program();
        end
    endtask

    // The receiver stops for a long stretch while items keep coming, so the
    // block fills up and refuses further input transfers.
    task automatic test_backpressure();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_request = 400;
        repeat (30) send_item(random_item());
        drain_results();
    endtask

    always @(negedge i_clk) begin
        if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge i_clk) begin : check_results
        tms_pkg::t_out want;
        if (i_rst_n && out_valid && out_ready) begin
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t: result with nothing expected, got %h", $time, out_item);
            end else begin
                want = pending_results.pop_front();
                check_field("out_symbol", want.out_symbol, out_item.out_symbol);
                check_field("out_state", want.out_state, out_item.out_state);
                check_field("out_head", 8'(want.out_head), 8'(out_item.out_head));
                check_field("status", 8'(want.status), 8'(out_item.status));
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_valid && in_ready) || (out_valid && out_ready)
                || (cfg_valid && cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;
        tx_idle_pct = 11;
        rx_idle_pct = 61;
        load_machine();
        test_directed();
        test_random_mix(11, 61, 8'h00, 6'd0, 5'd16);
        test_random_mix(61, 11, 8'hFF, 6'd63, tms_pkg::RULE_CNT_W'($urandom_range(15, 1)));
        test_random_mix(0, 0, tms_pkg::STATE_W'($urandom_range(255)),
            tms_pkg::HEAD_W'($urandom_range(63)), 5'd16);
        test_backpressure();
        drain_results();
        $display("Covered %0d items with %0d steps and %0d halts under three idle mixes,",
            items_sent, steps_run, halts_seen);
        $display("edge, marker, stop and missing-rule halts, and a long output stall.");
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
